// File: rtl/core/assert_macros.svh
// Assertion macros for the checker file lc2bc_checker.
// Needs nothing else; take it in by `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

// File: rtl/core/lc2bc_pkg.sv
// Types and constants for the line-comment to block-comment converter.
// No dependencies; used by line_comment_to_block_comment, lc2bc_decode and the testbench.
package lc2bc_pkg;

   localparam int MaxBeats   = 4;
   localparam int CountWidth = $clog2(MaxBeats + 1);

   localparam logic [7:0] ChQuote     = 8'h22;
   localparam logic [7:0] ChApos      = 8'h27;
   localparam logic [7:0] ChBackslash = 8'h5c;
   localparam logic [7:0] ChSlash     = 8'h2f;
   localparam logic [7:0] ChStar      = 8'h2a;
   localparam logic [7:0] ChNewline   = 8'h0a;
   localparam logic [7:0] ChSpace     = 8'h20;

   typedef enum logic [3:0] {
      ST_CODE     = 4'd0,
      ST_CHR      = 4'd1,
      ST_CHR_ESC  = 4'd2,
      ST_STR      = 4'd3,
      ST_STR_ESC  = 4'd4,
      ST_SLASH    = 4'd5,
      ST_LINE     = 4'd6,
      ST_BLOCK    = 4'd7,
      ST_STAR     = 4'd8
   } scan_state_type;

   typedef enum logic [1:0] {
      END_NONE  = 2'd0,
      END_CLEAN = 2'd1,
      END_BAD   = 2'd2
   } end_status_type;

   typedef struct packed {
      logic [7:0]     out_byte;
      logic           byte_valid;
      logic           last;
      end_status_type end_status;
   } beat_type;

   typedef struct packed {
      scan_state_type              next_state;
      logic [CountWidth-1:0]       count;
      beat_type [MaxBeats-1:0]     beats;
   } decode_type;

endpackage

// File: rtl/core/line_comment_to_block_comment.sv
// Top level of the line-comment to block-comment converter.
// Depends on lc2bc_pkg and lc2bc_decode.
//
// Rewrites each double-slash comment of a C text, given one byte per request, as a
// slash-star comment. A request passes an input register, is decoded against the scan
// state and lands in a four-entry result shift register, whose head drives the result
// port. One request can be taken every cycle as long as the held request can move on into
// the result register; a request that yields several results holds the result register
// until its last result is taken, and a slash in code yields no result. rsp_tuser[0] is
// byte_valid, rsp_tuser[2:1] is end_status (0 none, 1 clean end, 2 ended inside a literal,
// a block comment or after a pending slash); tlast marks the final result of a request.
module line_comment_to_block_comment (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [0] byte_valid, [2:1] end_status
   output logic       rsp_tlast
);

   localparam int MaxBeats = lc2bc_pkg::MaxBeats;
   localparam int CntW     = lc2bc_pkg::CountWidth;

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      in_eos_ff;
   lc2bc_pkg::scan_state_type state_ff, state_in;
   lc2bc_pkg::beat_type [MaxBeats-1:0] beats_ff, beats_in;
   logic [CntW-1:0]           count_ff, count_in;

   lc2bc_pkg::decode_type dec;
   logic                  pop, burst_free, load, req_take;

   lc2bc_decode u_decode (
      .state         (state_ff),
      .in_byte       (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .dec           (dec)
   );

   assign pop        = rsp_tvalid && rsp_tready;
   assign burst_free = (count_ff == '0) || (pop && count_ff == CntW'(1));
   assign load       = in_valid_ff && burst_free;
   assign req_tready = !in_valid_ff || load;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = req_take ? 1'b1 : (load ? 1'b0 : in_valid_ff);
      state_in    = load ? dec.next_state : state_ff;
      beats_in    = beats_ff;
      count_in    = count_ff;
      if (load) begin
         beats_in = dec.beats;
         count_in = dec.count;
      end else if (pop) begin
         for (int i = 0; i < MaxBeats - 1; i++) begin
            beats_in[i] = beats_ff[i+1];
         end
         beats_in[MaxBeats-1] = '0;
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= lc2bc_pkg::ST_CODE;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_eos_ff  <= req_tuser;
      end
      beats_ff <= beats_in;
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = beats_ff[0].out_byte;
   assign rsp_tuser  = {beats_ff[0].end_status, beats_ff[0].byte_valid};
   assign rsp_tlast  = beats_ff[0].last;

endmodule

// File: rtl/core/lc2bc_decode.sv
// Per-request decode: next scan state and the burst of up to four results.
// Depends on lc2bc_pkg.
module lc2bc_decode (
   input  lc2bc_pkg::scan_state_type state,
   input  logic [7:0]                in_byte,
   input  logic                      end_of_stream,
   output lc2bc_pkg::decode_type     dec
);

   logic [7:0]                       b0, b1, b2, b3;
   logic [lc2bc_pkg::CountWidth-1:0] count;
   logic                             status_only;
   lc2bc_pkg::end_status_type        status;
   lc2bc_pkg::scan_state_type        nxt;

   always_comb begin
      b0          = in_byte;
      b1          = 8'd0;
      b2          = 8'd0;
      b3          = 8'd0;
      count       = lc2bc_pkg::CountWidth'(1);
      status_only = 1'b0;
      status      = lc2bc_pkg::END_NONE;
      nxt         = state;
      if (end_of_stream) begin
         nxt = lc2bc_pkg::ST_CODE;
         if (state == lc2bc_pkg::ST_LINE) begin
            // close the open comment
            b0     = lc2bc_pkg::ChSpace;
            b1     = lc2bc_pkg::ChStar;
            b2     = lc2bc_pkg::ChSlash;
            count  = lc2bc_pkg::CountWidth'(3);
            status = lc2bc_pkg::END_CLEAN;
         end else begin
            b0          = 8'd0;
            status_only = 1'b1;
            case (state)
               lc2bc_pkg::ST_CHR, lc2bc_pkg::ST_CHR_ESC, lc2bc_pkg::ST_STR,
               lc2bc_pkg::ST_STR_ESC, lc2bc_pkg::ST_SLASH, lc2bc_pkg::ST_BLOCK,
               lc2bc_pkg::ST_STAR: status = lc2bc_pkg::END_BAD;
               default:            status = lc2bc_pkg::END_CLEAN;
            endcase
         end
      end else begin
         case (state)
            lc2bc_pkg::ST_STR: begin
               if (in_byte == lc2bc_pkg::ChBackslash) nxt = lc2bc_pkg::ST_STR_ESC;
               else if (in_byte == lc2bc_pkg::ChQuote) nxt = lc2bc_pkg::ST_CODE;
            end
            lc2bc_pkg::ST_STR_ESC: nxt = lc2bc_pkg::ST_STR;
            lc2bc_pkg::ST_CHR: begin
               if (in_byte == lc2bc_pkg::ChBackslash) nxt = lc2bc_pkg::ST_CHR_ESC;
               else if (in_byte == lc2bc_pkg::ChApos) nxt = lc2bc_pkg::ST_CODE;
            end
            lc2bc_pkg::ST_CHR_ESC: nxt = lc2bc_pkg::ST_CHR;
            lc2bc_pkg::ST_SLASH: begin
               // held slash goes out first; a quote here does not open a literal
               b0    = lc2bc_pkg::ChSlash;
               b1    = in_byte;
               count = lc2bc_pkg::CountWidth'(2);
               if (in_byte == lc2bc_pkg::ChSlash) begin
                  nxt = lc2bc_pkg::ST_LINE;
                  b1  = lc2bc_pkg::ChStar;
               end else if (in_byte == lc2bc_pkg::ChStar) begin
                  nxt = lc2bc_pkg::ST_BLOCK;
               end else begin
                  nxt = lc2bc_pkg::ST_CODE;
               end
            end
            lc2bc_pkg::ST_LINE: begin
               if (in_byte == lc2bc_pkg::ChNewline) begin
                  nxt   = lc2bc_pkg::ST_CODE;
                  b0    = lc2bc_pkg::ChSpace;
                  b1    = lc2bc_pkg::ChStar;
                  b2    = lc2bc_pkg::ChSlash;
                  b3    = in_byte;
                  count = lc2bc_pkg::CountWidth'(4);
               end
            end
            lc2bc_pkg::ST_BLOCK: begin
               if (in_byte == lc2bc_pkg::ChStar) nxt = lc2bc_pkg::ST_STAR;
            end
            lc2bc_pkg::ST_STAR: begin
               if (in_byte == lc2bc_pkg::ChSlash) nxt = lc2bc_pkg::ST_CODE;
               else if (in_byte != lc2bc_pkg::ChStar) nxt = lc2bc_pkg::ST_BLOCK;
            end
            default: begin
               if (in_byte == lc2bc_pkg::ChQuote) begin
                  nxt = lc2bc_pkg::ST_STR;
               end else if (in_byte == lc2bc_pkg::ChApos) begin
                  nxt = lc2bc_pkg::ST_CHR;
               end else if (in_byte == lc2bc_pkg::ChSlash) begin
                  nxt   = lc2bc_pkg::ST_SLASH;
                  count = '0;
               end else begin
                  nxt = lc2bc_pkg::ST_CODE;
               end
            end
         endcase
      end
   end

   always_comb begin
      dec.next_state = nxt;
      dec.count      = count;
      dec.beats[0].out_byte = b0;
      dec.beats[1].out_byte = b1;
      dec.beats[2].out_byte = b2;
      dec.beats[3].out_byte = b3;
      for (int i = 0; i < lc2bc_pkg::MaxBeats; i++) begin
         dec.beats[i].byte_valid = !status_only;
         dec.beats[i].last       = (count == lc2bc_pkg::CountWidth'(i + 1));
         dec.beats[i].end_status = (count == lc2bc_pkg::CountWidth'(i + 1))
                                   ? status : lc2bc_pkg::END_NONE;
      end
   end

endmodule

// File: rtl/core/lc2bc_checker.sv
// Port-level checks for the converter, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lc2bc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   // stalled result must not change
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // status-only result: zero byte, final, and carries an end code
   `ASSERT_CLK(a_status_only, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 8'd0 && rsp_tuser[2:1] != 2'd0)

   // an end code only ever sits on the final result of a request
   `ASSERT_CLK(a_status_last, clock, reset, rsp_tvalid && rsp_tuser[2:1] != 2'd0 |-> rsp_tlast)

   `ASSERT_NEVER(a_status_code, clock, reset, rsp_tvalid && rsp_tuser[2:1] == 2'd3)

   // nothing is in flight straight out of reset
   `ASSERT_CLK(a_reset_empty, clock, reset, $past(reset) |-> !rsp_tvalid)

endmodule

bind line_comment_to_block_comment lc2bc_checker u_lc2bc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: test/testbench.sv
// Self-checking bench for line_comment_to_block_comment, the comment rewriting stream block.
// Needs lc2bc_pkg for the scan states, end codes and character constants.
// Directed text comes first, then random C-like fragments, checked by a scoreboard class.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lc2bc_pkg::*;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       req_tuser  = 1'b0;    // [0] end_of_stream
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic [2:0] rsp_tuser;            // [0] byte_valid, [2:1] end_status
   logic       rsp_tlast;

   int send_idle = 14;
   int recv_idle = 46;
   int requests_sent = 0;

   line_comment_to_block_comment dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   class comment_rewriter;
      scan_state_type scan;
      beat_type       burst[$];
      beat_type       rewritten_beats[$];
      int             errors;

      function new();
         scan   = ST_CODE;
         errors = 0;
      endfunction

      function void add_byte(logic [7:0] b);
         beat_type beat;
         beat.out_byte   = b;
         beat.byte_valid = 1'b1;
         beat.last       = 1'b0;
         beat.end_status = END_NONE;
         burst.push_back(beat);
      endfunction

      function void close_burst(end_status_type status);
         beat_type tail;
         tail            = burst.pop_back();
         tail.last       = 1'b1;
         tail.end_status = status;
         burst.push_back(tail);
      endfunction

      function int pending();
         return rewritten_beats.size();
      endfunction

      function void rewrite_request(logic [7:0] b, logic eos);
         beat_type status_beat;
         burst.delete();
         if (eos) begin
            if (scan == ST_LINE) begin
               add_byte(ChSpace);
               add_byte(ChStar);
               add_byte(ChSlash);
               close_burst(END_CLEAN);
            end else begin
               status_beat.out_byte   = 8'h00;
               status_beat.byte_valid = 1'b0;
               status_beat.last       = 1'b0;
               status_beat.end_status = END_NONE;
               burst.push_back(status_beat);
               close_burst(scan == ST_CODE ? END_CLEAN : END_BAD);
            end
            scan = ST_CODE;
         end else begin
            case (scan)
               ST_STR: begin
                  if (b == ChBackslash) scan = ST_STR_ESC;
                  else if (b == ChQuote) scan = ST_CODE;
                  add_byte(b);
               end
               ST_STR_ESC: begin
                  scan = ST_STR;
                  add_byte(b);
               end
               ST_CHR: begin
                  if (b == ChBackslash) scan = ST_CHR_ESC;
                  else if (b == ChApos) scan = ST_CODE;
                  add_byte(b);
               end
               ST_CHR_ESC: begin
                  scan = ST_CHR;
                  add_byte(b);
               end
               ST_SLASH: begin
                  // the held slash goes out first; a quote here does not open a literal
                  add_byte(ChSlash);
                  if (b == ChSlash) begin
                     scan = ST_LINE;
                     add_byte(ChStar);
                  end else if (b == ChStar) begin
                     scan = ST_BLOCK;
                     add_byte(ChStar);
                  end else begin
                     scan = ST_CODE;
                     add_byte(b);
                  end
               end
               ST_LINE: begin
                  if (b == ChNewline) begin
                     scan = ST_CODE;
                     add_byte(ChSpace);
                     add_byte(ChStar);
                     add_byte(ChSlash);
                  end
                  add_byte(b);
               end
               ST_BLOCK: begin
                  if (b == ChStar) scan = ST_STAR;
                  add_byte(b);
               end
               ST_STAR: begin
                  if (b == ChSlash) scan = ST_CODE;
                  else if (b != ChStar) scan = ST_BLOCK;
                  add_byte(b);
               end
               default: begin
                  if (b == ChQuote) begin
                     scan = ST_STR;
                     add_byte(b);
                  end else if (b == ChApos) begin
                     scan = ST_CHR;
                     add_byte(b);
                  end else if (b == ChSlash) begin
                     scan = ST_SLASH;   // held back, nothing out yet
                  end else begin
                     scan = ST_CODE;
                     add_byte(b);
                  end
               end
            endcase
            if (burst.size() > 0) close_burst(END_NONE);
         end
         foreach (burst[i]) rewritten_beats.push_back(burst[i]);
      endfunction

      function void match_response(logic [7:0] data, logic [2:0] user, logic last);
         beat_type want;
         if (rewritten_beats.size() == 0) begin
            $error("response with nothing expected: out_byte %h, tuser %b", data, user);
            errors++;
            return;
         end
         want = rewritten_beats.pop_front();
         if (data !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, data);
            errors++;
         end
         if (user[0] !== want.byte_valid) begin
            $error("byte_valid: expected %b, got %b", want.byte_valid, user[0]);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, got %b", want.last, last);
            errors++;
         end
         if (user[2:1] !== want.end_status) begin
            $error("end_status: expected %0d, got %0d", want.end_status, user[2:1]);
            errors++;
         end
      endfunction
   endclass

   comment_rewriter rewriter = new();

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random back-pressure, check each accepted response
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) rewriter.match_response(rsp_tdata, rsp_tuser, rsp_tlast);
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   task automatic send_request(logic [7:0] b, logic eos);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rewriter.rewrite_request(b, eos);
      requests_sent++;
   endtask

   task automatic send_end();
      send_request(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 11))
         0:       return ChQuote;
         1:       return ChApos;
         2:       return ChBackslash;
         3:       return ChSlash;
         4:       return ChStar;
         5:       return ChNewline;
         6:       return ChSpace;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one C-like fragment; now and then the text is cut short by an end of stream
   task automatic send_fragment();
      int kind;
      int len;
      bit broken;
      kind   = $urandom_range(0, 9);
      len    = $urandom_range(0, 6);
      broken = ($urandom_range(0, 5) == 0);
      case (kind)
         0, 1: repeat (len + 1) send_request(pick_byte(), 1'b0);
         2: begin
            send_request(ChQuote, 1'b0);
            repeat (len) send_request(pick_byte(), 1'b0);
            if (broken) send_end();
            else send_request(ChQuote, 1'b0);
         end
         3: begin
            send_request(ChApos, 1'b0);
            if ($urandom_range(0, 2) == 0) send_request(ChBackslash, 1'b0);
            send_request(pick_byte(), 1'b0);
            if (broken) send_end();
            else send_request(ChApos, 1'b0);
         end
         4, 5: begin
            send_request(ChSlash, 1'b0);
            send_request(ChSlash, 1'b0);
            repeat (len) send_request(pick_byte(), 1'b0);
            if (broken) send_end();
            else send_request(ChNewline, 1'b0);
         end
         6: begin
            send_request(ChSlash, 1'b0);
            send_request(ChStar, 1'b0);
            repeat (len) send_request(pick_byte(), 1'b0);
            if (broken) begin
               send_end();
            end else begin
               send_request(ChStar, 1'b0);
               send_request(ChSlash, 1'b0);
            end
         end
         7: send_request(ChNewline, 1'b0);
         8: send_end();
         default: begin
            repeat (len + 1)
               send_request(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end
      endcase
   endtask

   // drop valid first so the last request is not taken again while waiting
   task automatic drain();
      req_tvalid <= 1'b0;
      while (rewriter.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: byte extremes, slash then quote, clean end in code
      send_request(8'h00, 1'b0);
      send_request(8'hff, 1'b0);
      send_request(ChSlash, 1'b0);
      send_request(ChQuote, 1'b0);
      send_end();
      // string with an escaped quote, then a char literal with an escape
      send_request(ChQuote, 1'b0);
      send_request(ChBackslash, 1'b0);
      send_request(ChQuote, 1'b0);
      send_request(ChQuote, 1'b0);
      send_request(ChApos, 1'b0);
      send_request(ChBackslash, 1'b0);
      send_request(ChApos, 1'b0);
      send_request(ChApos, 1'b0);
      // block comment with a run of stars
      send_request(ChSlash, 1'b0);
      send_request(ChStar, 1'b0);
      send_request(ChStar, 1'b0);
      send_request(ChStar, 1'b0);
      send_request(ChSlash, 1'b0);
      // line comment closed by newline, then one closed by end of stream
      send_request(ChSlash, 1'b0);
      send_request(ChSlash, 1'b0);
      send_request(ChNewline, 1'b0);
      send_request(ChSlash, 1'b0);
      send_request(ChSlash, 1'b0);
      send_end();
      // bad ends: inside a string, and with a slash held back
      send_request(ChQuote, 1'b0);
      send_end();
      send_request(ChSlash, 1'b0);
      send_end();

      while (requests_sent < 175) send_fragment();
      drain();
      send_idle = 46;
      recv_idle = 14;
      while (requests_sent < 320) send_fragment();
      drain();
      send_idle = 0;
      recv_idle = 0;
      while (requests_sent < 465) send_fragment();
      drain();

      repeat (8) @(posedge clock);
      if (rewriter.errors == 0 && rewriter.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
